>>> sv/mm2_pkg.sv
// Shared constants and command types for the MurmurHash2 engine.
// No dependencies; compiled before all other files.
package mm2_pkg;

  localparam int WORD_W       = 32;
  localparam int BYTE_COUNT_W = 3;
  localparam int PADDR_W      = 3;

  localparam logic [WORD_W-1:0] MIX_MUL = 32'h5bd1e995;
  localparam int WORD_SHIFT    = 24;
  localparam int FINAL_SHIFT_A = 13;
  localparam int FINAL_SHIFT_B = 15;

  // register index decoded from paddr[2]
  localparam logic REG_HASH_SEED = 1'b0;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MIX_K1,
    OP_MIX_K2,
    OP_MIX_H,
    OP_TAIL,
    OP_FINAL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

endpackage

>>> sv/mm2_key_if.sv
// Key word channel: valid/ready handshake plus the key word payload.
// Depends on mm2_pkg for field widths.
interface mm2_key_if;
  logic                              valid;
  logic                              ready;
  logic [mm2_pkg::WORD_W-1:0]        key_word;
  logic [mm2_pkg::BYTE_COUNT_W-1:0]  byte_count;
  logic                              first_word;
  logic                              last_word;
  logic [mm2_pkg::WORD_W-1:0]        total_length;

  modport source (output valid, key_word, byte_count, first_word, last_word,
                  total_length, input ready);
  modport sink (input valid, key_word, byte_count, first_word, last_word,
                total_length, output ready);
endinterface

>>> sv/mm2_hash_if.sv
// Hash result channel: valid/ready handshake plus the finished hash.
// Depends on mm2_pkg for field widths.
interface mm2_hash_if;
  logic                        valid;
  logic                        ready;
  logic [mm2_pkg::WORD_W-1:0]  hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

>>> sv/mm2_ctrl.sv
// Sequencer for the hash engine: walks each key word through the shared
// multiplier steps and owns the result valid flag. Depends on mm2_pkg.
module mm2_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [mm2_pkg::BYTE_COUNT_W-1:0] byte_count,
  input  logic                             last_word,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mm2_pkg::dp_cmd_t                 cmd
);
  import mm2_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_HMIX,
    S_TAIL,
    S_FINAL
  } state_t;

  state_t state, state_next;
  logic   last_pend;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.op     = OP_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op = OP_LOAD;
          if (byte_count[2]) begin
            state_next = S_K1;
          end else if (byte_count != '0) begin
            state_next = S_TAIL;
          end else if (last_word) begin
            state_next = S_FINAL;
          end
        end
      end
      S_K1: begin
        cmd.op     = OP_MIX_K1;
        state_next = S_K2;
      end
      S_K2: begin
        cmd.op     = OP_MIX_K2;
        state_next = S_HMIX;
      end
      S_HMIX: begin
        cmd.op     = OP_MIX_H;
        state_next = last_pend ? S_FINAL : S_IDLE;
      end
      S_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = last_pend ? S_FINAL : S_IDLE;
      end
      S_FINAL: begin
        // hold until the result register can take the new hash
        if (out_free) begin
          cmd.op     = OP_FINAL;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_pend <= last_word;
      end
      if (cmd.op == OP_FINAL) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/mm2_datapath.sv
// Hash datapath: running hash, word register, one shared 32-bit multiplier
// and the result register. Depends on mm2_pkg.
module mm2_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  mm2_pkg::dp_cmd_t                 cmd,
  input  logic [mm2_pkg::WORD_W-1:0]       hash_seed,
  input  logic [mm2_pkg::WORD_W-1:0]       key_word,
  input  logic [mm2_pkg::BYTE_COUNT_W-1:0] byte_count,
  input  logic                             first_word,
  input  logic [mm2_pkg::WORD_W-1:0]       total_length,
  output logic [mm2_pkg::WORD_W-1:0]       hash_value
);
  import mm2_pkg::*;

  logic [WORD_W-1:0] h;
  logic [WORD_W-1:0] k;
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] fin;
  logic [WORD_W-1:0] mask;

  // tail bytes beyond byte_count are dropped at load time
  always_comb begin
    case (byte_count)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_MIX_K1: mul_a = k;
      OP_MIX_K2: mul_a = k ^ (k >> WORD_SHIFT);
      OP_MIX_H:  mul_a = h;
      OP_TAIL:   mul_a = h ^ k;
      OP_FINAL:  mul_a = h ^ (h >> FINAL_SHIFT_A);
      default:   mul_a = '0;
    endcase
  end

  assign prod = mul_a * MIX_MUL;
  assign fin  = prod ^ (prod >> FINAL_SHIFT_B);

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (first_word) begin
            h <= hash_seed ^ total_length;
          end
          k <= key_word & mask;
        end
        OP_MIX_K1: k <= prod;
        OP_MIX_K2: k <= prod;
        OP_MIX_H:  h <= prod ^ k;
        OP_TAIL:   h <= prod;
        OP_FINAL: begin
          h          <= fin;
          hash_value <= fin;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/murmur2_hash_engine_core.sv
// Top level of the MurmurHash2 engine: APB seed register, controller and
// datapath. Depends on mm2_pkg, mm2_key_if, mm2_hash_if, mm2_ctrl, mm2_datapath.

// Computes the 32-bit MurmurHash2 of a key streamed as little-endian words.
// One key word is in flight at a time and all multiplies share a single
// 32x32 multiplier, one multiply per cycle: a full word runs load, two key
// multiplies and a hash multiply, a 1-3 byte tail load and a tail multiply,
// a zero-byte item load alone; the last word of a key adds the avalanche
// step. The finished hash sits in an output register, so the next key word
// can be accepted while the result waits to be taken; the avalanche step
// waits only if the previous hash is still unclaimed. hash_seed lives at
// byte address 0; write it only between keys (not enforced by the block).
module murmur2_hash_engine_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mm2_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  mm2_key_if.sink                       key_in,
  mm2_hash_if.source                    hash_out
);
  import mm2_pkg::*;

  logic [WORD_W-1:0] hash_seed;
  logic              cfg_write;
  dp_cmd_t           cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (cfg_write && (paddr[2] == REG_HASH_SEED)) begin
      hash_seed <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_HASH_SEED) ? hash_seed : '0;

  mm2_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (key_in.valid),
    .byte_count (key_in.byte_count),
    .last_word  (key_in.last_word),
    .in_ready   (key_in.ready),
    .out_valid  (hash_out.valid),
    .out_ready  (hash_out.ready),
    .cmd        (cmd)
  );

  mm2_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .hash_seed    (hash_seed),
    .key_word     (key_in.key_word),
    .byte_count   (key_in.byte_count),
    .first_word   (key_in.first_word),
    .total_length (key_in.total_length),
    .hash_value   (hash_out.hash_value)
  );

endmodule
